// ===== design/eid_pkg.sv =====
// ----------------------------------------------------------------------------
// eid_pkg
// Shared types and codes of the entity identifier allocator: request and
// result transactions, the command carried from front to back, and the codes.
// ----------------------------------------------------------------------------
package eid_pkg;

    // field widths of the transactions
    localparam int REQ_W    = 2;
    localparam int ID_IN_W  = 16;
    localparam int SIG_IN_W = 32;
    localparam int STATUS_W = 3;
    localparam int NEW_ID_W = 10;
    localparam int COUNT_W  = 11;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CREATE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DESTROY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SET     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NONE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DEAD  = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [ID_IN_W-1:0]  entity_id;
        logic [SIG_IN_W-1:0] sig_in;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NEW_ID_W-1:0] new_id;
        logic                is_alive;
        logic [SIG_IN_W-1:0] sig_out;
        logic [COUNT_W-1:0]  live_count;
    } rsp_item_t;

    // classified request, as queued between front and back
    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic                in_range;
        logic [ID_IN_W-1:0]  entity_id;
        logic [SIG_IN_W-1:0] sig_in;
    } cmd_t;

    // fill state of the command queue, seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// ===== design/eid_chan_if.sv =====
// ----------------------------------------------------------------------------
// eid_chan_if
// Valid/ready channel carrying one payload struct per transaction.
// ----------------------------------------------------------------------------
interface eid_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/eid_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// eid_cmd_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module eid_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  eid_pkg::cmd_t       push_cmd,
    input  logic                pop,
    output eid_pkg::cmd_t       pop_cmd,
    output eid_pkg::fifo_stat_t stat
);
    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    eid_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

// ===== design/eid_front.sv =====
// ----------------------------------------------------------------------------
// eid_front
// Accepts request transactions, range-checks the identifier and queues the
// classified command for the back.
// ----------------------------------------------------------------------------
module eid_front #(
    parameter int NUM_IDS = 1024
) (
    eid_chan_if.sink            req,
    input  logic                clearing,
    input  eid_pkg::fifo_stat_t fifo_stat,
    output logic                push,
    output eid_pkg::cmd_t       push_cmd
);
    localparam int CMP_W = eid_pkg::ID_IN_W + 1;

    // hold off requests while the stores are swept or the queue is full
    assign req.ready = !clearing && !fifo_stat.full;
    assign push      = req.valid && req.ready;

    assign push_cmd.req_type  = req.data.req_type;
    assign push_cmd.in_range  = ({1'b0, req.data.entity_id} < CMP_W'(NUM_IDS));
    assign push_cmd.entity_id = req.data.entity_id;
    assign push_cmd.sig_in    = req.data.sig_in;

endmodule

// ===== design/eid_back.sv =====
// ----------------------------------------------------------------------------
// eid_back
// Carries out queued commands against the free queue, alive and signature
// stores; sweeps the stores after reset and holds the result register.
// ----------------------------------------------------------------------------
module eid_back #(
    parameter int NUM_IDS  = 1024,
    parameter int SIG_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  eid_pkg::cmd_t       pop_cmd,
    input  eid_pkg::fifo_stat_t fifo_stat,
    output logic                pop,
    output logic                clearing,
    eid_chan_if.source          rsp
);
    localparam int IW = $clog2(NUM_IDS);
    localparam int CW = $clog2(NUM_IDS + 1);
    localparam int SW = (SIG_BITS < eid_pkg::SIG_IN_W) ? SIG_BITS : eid_pkg::SIG_IN_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    // stores
    logic          alive_mem [NUM_IDS];
    logic [SW-1:0] sig_mem   [NUM_IDS];
    logic [IW-1:0] q_mem     [NUM_IDS];

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [IW-1:0] clr_reg;
    logic [IW-1:0] clr_next;
    logic [IW-1:0] head_reg;
    logic [IW-1:0] head_next;
    logic [IW-1:0] tail_reg;
    logic [IW-1:0] tail_next;
    logic          wrapped_reg;
    logic          wrapped_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    eid_pkg::rsp_item_t rsp_reg;
    eid_pkg::rsp_item_t rsp_next;
    eid_pkg::cmd_t      cmd_reg;
    logic          fresh_reg;
    logic          alive_rd_reg;
    logic [SW-1:0] sig_rd_reg;
    logic [IW-1:0] q_rd_reg;

    logic          rd_en;
    logic [IW-1:0] rd_id;
    logic          fresh_now;
    logic          alive_we;
    logic [IW-1:0] alive_waddr;
    logic          alive_wdata;
    logic          sig_we;
    logic [IW-1:0] sig_waddr;
    logic [SW-1:0] sig_wdata;
    logic          q_we;

    logic [IW-1:0] id;
    logic [IW-1:0] got;
    logic          out_free;
    logic [IW+eid_pkg::NEW_ID_W-1:0]  nid_ext;
    logic [CW+eid_pkg::COUNT_W-1:0]   cnt_ext;
    logic [SW+eid_pkg::SIG_IN_W-1:0]  sig_ext;

    assign id       = cmd_reg.entity_id[IW-1:0];
    assign got      = fresh_reg ? head_reg : q_rd_reg;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign rd_id    = pop_cmd.entity_id[IW-1:0];
    // a queue slot not yet written since reset still holds its own index
    assign fresh_now = !(wrapped_reg || (head_reg < tail_reg));
    assign nid_ext  = {{eid_pkg::NEW_ID_W{1'b0}}, got};
    assign cnt_ext  = {{eid_pkg::COUNT_W{1'b0}}, count_next};
    assign sig_ext  = {{eid_pkg::SIG_IN_W{1'b0}}, sig_rd_reg};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        wrapped_next   = wrapped_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        alive_we       = 1'b0;
        alive_waddr    = id;
        alive_wdata    = 1'b0;
        sig_we         = 1'b0;
        sig_waddr      = id;
        sig_wdata      = '0;
        q_we           = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                alive_we    = 1'b1;
                alive_waddr = clr_reg;
                sig_we      = 1'b1;
                sig_waddr   = clr_reg;
                if (clr_reg == IW'(NUM_IDS - 1))
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    clr_next = clr_reg + IW'(1);
                end
            end
            S_FETCH:
            begin
                if (!fifo_stat.empty)
                begin
                    pop        = 1'b1;
                    rd_en      = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    rsp_next.status   = eid_pkg::ST_OK;
                    rsp_next.new_id   = '0;
                    rsp_next.is_alive = 1'b0;
                    rsp_next.sig_out  = '0;
                    case (cmd_reg.req_type)
                        eid_pkg::REQ_CREATE:
                        begin
                            if (count_reg == CW'(NUM_IDS))
                            begin
                                rsp_next.status = eid_pkg::ST_FULL;
                            end
                            else
                            begin
                                alive_we        = 1'b1;
                                alive_waddr     = got;
                                alive_wdata     = 1'b1;
                                head_next       = (head_reg == IW'(NUM_IDS - 1)) ?
                                                  '0 : head_reg + IW'(1);
                                count_next      = count_reg + CW'(1);
                                rsp_next.new_id = nid_ext[eid_pkg::NEW_ID_W-1:0];
                            end
                        end
                        eid_pkg::REQ_DESTROY:
                        begin
                            if (!cmd_reg.in_range)
                            begin
                                rsp_next.status = eid_pkg::ST_RANGE;
                            end
                            else if (count_reg == '0)
                            begin
                                rsp_next.status = eid_pkg::ST_NONE;
                            end
                            else if (!alive_rd_reg)
                            begin
                                rsp_next.status = eid_pkg::ST_DEAD;
                            end
                            else
                            begin
                                alive_we   = 1'b1;
                                sig_we     = 1'b1;
                                q_we       = 1'b1;
                                count_next = count_reg - CW'(1);
                                if (tail_reg == IW'(NUM_IDS - 1))
                                begin
                                    tail_next    = '0;
                                    wrapped_next = 1'b1;
                                end
                                else
                                begin
                                    tail_next = tail_reg + IW'(1);
                                end
                            end
                        end
                        eid_pkg::REQ_SET:
                        begin
                            if (!cmd_reg.in_range)
                            begin
                                rsp_next.status = eid_pkg::ST_RANGE;
                            end
                            else
                            begin
                                sig_we    = 1'b1;
                                sig_wdata = cmd_reg.sig_in[SW-1:0];
                            end
                        end
                        eid_pkg::REQ_LOOKUP:
                        begin
                            if (!cmd_reg.in_range)
                            begin
                                rsp_next.status = eid_pkg::ST_RANGE;
                            end
                            else
                            begin
                                rsp_next.is_alive = alive_rd_reg;
                                rsp_next.sig_out  = sig_ext[eid_pkg::SIG_IN_W-1:0];
                            end
                        end
                        default:
                        begin
                            rsp_next.status = eid_pkg::ST_OK;
                        end
                    endcase
                    rsp_next.live_count = cnt_ext[eid_pkg::COUNT_W-1:0];
                    rsp_valid_next      = 1'b1;
                    state_next          = S_FETCH;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            wrapped_reg   <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            wrapped_reg   <= wrapped_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (rd_en)
        begin
            cmd_reg   <= pop_cmd;
            fresh_reg <= fresh_now;
        end
    end

    // store ports: one read address, one write address each
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            alive_rd_reg <= alive_mem[rd_id];
            sig_rd_reg   <= sig_mem[rd_id];
            q_rd_reg     <= q_mem[head_reg];
        end
        if (alive_we)
        begin
            alive_mem[alive_waddr] <= alive_wdata;
        end
        if (sig_we)
        begin
            sig_mem[sig_waddr] <= sig_wdata;
        end
        if (q_we)
        begin
            q_mem[tail_reg] <= id;
        end
    end

    assign clearing  = (state_reg == S_CLEAR);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

endmodule

// ===== design/entity_id_allocator.sv =====
// ----------------------------------------------------------------------------
// entity_id_allocator
// Identifier allocator with a FIFO free queue, per-identifier alive bit and
// signature word, and a live count returned with every result.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload              | transaction
//   --------+-----+----------------------+-------------------------------
//   req     | in  | eid_pkg::req_item_t  | create/destroy/set/lookup
//   rsp     | out | eid_pkg::rsp_item_t  | one result per request
//
// A request passes through the back's fetch state, which reads the stores
// and the free queue head, and then its execute state, which decides,
// writes back and loads the result register once that register is free.
// The read data is registered before the decision, so the back takes a new
// request only after it is through with the last one. After reset the back
// sweeps the alive and signature stores with req.ready low. The front queues
// up to two requests while the back waits on a stalled result.
// ----------------------------------------------------------------------------
module entity_id_allocator #(
    parameter int NUM_IDS  = 1024,
    parameter int SIG_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    eid_chan_if.sink   req,
    eid_chan_if.source rsp
);
    // front to back command path
    logic                fifo_push;
    logic                fifo_pop;
    eid_pkg::cmd_t       push_cmd;
    eid_pkg::cmd_t       pop_cmd;
    eid_pkg::fifo_stat_t fifo_stat;
    // high while the stores are swept after reset
    logic                clearing;

    // classify incoming requests and queue them
    eid_front #(
        .NUM_IDS (NUM_IDS)
    ) u_front (
        .req       (req),
        .clearing  (clearing),
        .fifo_stat (fifo_stat),
        .push      (fifo_push),
        .push_cmd  (push_cmd)
    );

    // decouple acceptance from execution
    eid_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_cmd (push_cmd),
        .pop      (fifo_pop),
        .pop_cmd  (pop_cmd),
        .stat     (fifo_stat)
    );

    // execute commands against the stores and drive results
    eid_back #(
        .NUM_IDS  (NUM_IDS),
        .SIG_BITS (SIG_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_cmd   (pop_cmd),
        .fifo_stat (fifo_stat),
        .pop       (fifo_pop),
        .clearing  (clearing),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    // no request is taken while the stores are swept
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !(req.valid && req.ready))
        else $error("request accepted during store sweep");

    // the back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> !fifo_stat.empty)
        else $error("command queue popped while empty");

    // a destroy refused for lack of live identifiers reports a zero count
    a_none_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status == eid_pkg::ST_NONE) |-> rsp.data.live_count == '0)
        else $error("none-alive status with nonzero live count");
`endif

endmodule

// ===== tb/tb_entity_id_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_entity_id_allocator
// Self-checking bench for the entity identifier allocator. It runs a directed
// table first, then random create/set/lookup/destroy traffic, a drain of the
// live set and a short mixed tail near empty. Every result is compared
// against a cycle-free predictor that keeps its own free queue, alive map and
// signature store. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_entity_id_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_IDS     = 1024;
    localparam int SIG_BITS    = 32;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 20;
    localparam int MIX_ITEMS   = 350;
    localparam int TAIL_ITEMS  = 30;

    // traffic profiles of the random part
    typedef enum int {
        MIX_RANDOM,
        MIX_DRAIN
    } mix_t;

    // result-side stall patterns
    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    // one row of the directed table; fixed_want marks a hand-typed result
    typedef struct {
        eid_pkg::req_item_t item;
        bit                 fixed_want;
        eid_pkg::rsp_item_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    eid_chan_if #(.payload_t(eid_pkg::req_item_t)) req_ch ();
    eid_chan_if #(.payload_t(eid_pkg::rsp_item_t)) rsp_ch ();

    entity_id_allocator #(
        .NUM_IDS  (NUM_IDS),
        .SIG_BITS (SIG_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------------
    // Clock: 2 ns period.
    // ------------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #1;
        clk = 1'b1;
        #1;
        clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a copy of the allocator's free queue, alive map,
    // signature store and live count.
    // ------------------------------------------------------------------------
    logic [eid_pkg::NEW_ID_W-1:0] id_fifo [NUM_IDS];
    logic [eid_pkg::NEW_ID_W-1:0] fifo_rd;
    logic [eid_pkg::NEW_ID_W-1:0] fifo_wr;
    logic                         alive_map [NUM_IDS];
    logic [eid_pkg::SIG_IN_W-1:0] sig_mem [NUM_IDS];
    logic [eid_pkg::COUNT_W-1:0]  live_total;

    eid_pkg::rsp_item_t pending_results [$];
    dir_row_t           directed_rows [$];
    int                 error_count;
    int                 cycle_count;
    int                 burst_left;
    int                 stall_left;
    rx_mode_t           stall_mode;

    // Load the power-up contents: queue holds 0..N-1, nothing alive.
    function automatic void clear_allocator_copy();
        for (int i = 0; i < NUM_IDS; i++)
        begin
            id_fifo[i]   = eid_pkg::NEW_ID_W'(i);
            alive_map[i] = 1'b0;
            sig_mem[i]   = '0;
        end
        fifo_rd    = '0;
        fifo_wr    = '0;
        live_total = '0;
    endfunction

    // Apply one request to the copy and return the result it must produce.
    // The 10-bit pointers wrap at NUM_IDS on their own.
    function automatic eid_pkg::rsp_item_t apply_request(eid_pkg::req_item_t r);
        eid_pkg::rsp_item_t           o;
        logic                         in_range;
        logic [eid_pkg::NEW_ID_W-1:0] idx;
        o          = '0;
        o.status   = eid_pkg::ST_OK;
        in_range   = (r.entity_id < NUM_IDS);
        idx        = r.entity_id[eid_pkg::NEW_ID_W-1:0];
        case (r.req_type)
            eid_pkg::REQ_CREATE:
            begin
                if (live_total >= NUM_IDS)
                    o.status = eid_pkg::ST_FULL;
                else
                begin
                    o.new_id            = id_fifo[fifo_rd];
                    fifo_rd             = fifo_rd + eid_pkg::NEW_ID_W'(1);
                    alive_map[o.new_id] = 1'b1;
                    live_total          = live_total + eid_pkg::COUNT_W'(1);
                end
            end
            eid_pkg::REQ_DESTROY:
            begin
                if (!in_range)
                    o.status = eid_pkg::ST_RANGE;
                else if (live_total == 0)
                    o.status = eid_pkg::ST_NONE;
                else if (!alive_map[idx])
                    o.status = eid_pkg::ST_DEAD;
                else
                begin
                    sig_mem[idx]     = '0;
                    alive_map[idx]   = 1'b0;
                    id_fifo[fifo_wr] = idx;
                    fifo_wr          = fifo_wr + eid_pkg::NEW_ID_W'(1);
                    live_total       = live_total - eid_pkg::COUNT_W'(1);
                end
            end
            eid_pkg::REQ_SET:
            begin
                if (!in_range)
                    o.status = eid_pkg::ST_RANGE;
                else
                    sig_mem[idx] = r.sig_in;
            end
            default:
            begin
                if (!in_range)
                    o.status = eid_pkg::ST_RANGE;
                else
                begin
                    o.is_alive = alive_map[idx];
                    o.sig_out  = sig_mem[idx];
                end
            end
        endcase
        o.live_count = live_total;
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------------

    // Return a random alive identifier, or -1 if none is alive.
    function automatic int pick_live_id();
        int start;
        int k;
        start = $urandom_range(0, NUM_IDS - 1);
        for (int i = 0; i < NUM_IDS; i++)
        begin
            k = (start + i) % NUM_IDS;
            if (alive_map[k])
                return k;
        end
        return -1;
    endfunction

    // Aim mostly at live identifiers so destroy/set/lookup do real work;
    // mix in random in-range ids and the full 16-bit range for range errors.
    function automatic logic [eid_pkg::ID_IN_W-1:0] pick_target(int live_pct);
        int roll;
        int live_id;
        roll    = $urandom_range(0, 99);
        live_id = pick_live_id();
        if (roll < live_pct && live_id >= 0)
            return eid_pkg::ID_IN_W'(live_id);
        else if (roll < live_pct + (100 - live_pct) * 2 / 3)
            return eid_pkg::ID_IN_W'($urandom_range(0, NUM_IDS - 1));
        return eid_pkg::ID_IN_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [eid_pkg::SIG_IN_W-1:0] pick_sig();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic eid_pkg::req_item_t make_request(mix_t mix);
        eid_pkg::req_item_t r;
        int                 roll;
        roll        = $urandom_range(0, 99);
        r.sig_in    = pick_sig();
        r.entity_id = pick_target(70);
        case (mix)
            MIX_DRAIN:
            begin
                if (roll < 85)
                begin
                    r.req_type  = eid_pkg::REQ_DESTROY;
                    r.entity_id = pick_target(95);
                end
                else if (roll < 92)
                    r.req_type = eid_pkg::REQ_SET;
                else
                    r.req_type = eid_pkg::REQ_LOOKUP;
            end
            default:
            begin
                if (roll < 30)
                    r.req_type = eid_pkg::REQ_CREATE;
                else if (roll < 55)
                    r.req_type = eid_pkg::REQ_DESTROY;
                else if (roll < 75)
                    r.req_type = eid_pkg::REQ_SET;
                else
                    r.req_type = eid_pkg::REQ_LOOKUP;
            end
        endcase
        // create ignores the id; give it random bits anyway
        if (r.req_type == eid_pkg::REQ_CREATE)
            r.entity_id = eid_pkg::ID_IN_W'($urandom_range(0, 65535));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Called at a falling edge; returns at the falling edge
    // after the transaction is accepted. The driver lowers valid only when a
    // gap starts, so a burst keeps valid high across back-to-back transactions.
    // ------------------------------------------------------------------------
    task automatic send_request(eid_pkg::req_item_t item, bit fixed_want,
                                eid_pkg::rsp_item_t want);
        int                 gap;
        eid_pkg::rsp_item_t predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        // wait for the handshake
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // advance the copy on acceptance; a hand-typed result overrides it
        predicted = apply_request(item);
        pending_results.insert(pending_results.size(), fixed_want ? want : predicted);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_random(mix_t mix);
        send_request(make_request(mix), 1'b0, '0);
    endtask

    // Drop valid and hold until every expected result is back.
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic void add_row(logic [eid_pkg::REQ_W-1:0] req_type, int id,
                                    logic [31:0] sig, bit fixed_want,
                                    logic [eid_pkg::STATUS_W-1:0] status,
                                    int new_id, bit alive, logic [31:0] sig_out,
                                    int count);
        dir_row_t row;
        row.item.req_type    = req_type;
        row.item.entity_id   = eid_pkg::ID_IN_W'(id);
        row.item.sig_in      = sig;
        row.fixed_want       = fixed_want;
        row.want.status      = status;
        row.want.new_id      = eid_pkg::NEW_ID_W'(new_id);
        row.want.is_alive    = alive;
        row.want.sig_out     = sig_out;
        row.want.live_count  = eid_pkg::COUNT_W'(count);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: stall on a pattern that is chosen anew at random.
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        stall_mode   = RX_OPEN;
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = rx_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 96);
        end
        else
            stall_left--;
        case (stall_mode)
            RX_OPEN:     rsp_ch.ready <= 1'b1;
            RX_LIGHT:    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_ch.ready <= (stall_left % 16 >= 6);
        endcase
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------------
    task automatic check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", fname, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        eid_pkg::rsp_item_t want;
        eid_pkg::rsp_item_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: status 0x%0h new_id 0x%0h",
                       got.status, got.new_id);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status",     32'(want.status),     32'(got.status));
                check_field("new_id",     32'(want.new_id),     32'(got.new_id));
                check_field("is_alive",   32'(want.is_alive),   32'(got.is_alive));
                check_field("sig_out",    want.sig_out,         got.sig_out);
                check_field("live_count", 32'(want.live_count), 32'(got.live_count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: the slowest correct run is far below this.
    // ------------------------------------------------------------------------
    initial cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        error_count  = 0;
        burst_left   = 0;
        clear_allocator_copy();

        // Directed table. Rows typed by hand cover the reset state, the range,
        // none-alive and dead status codes and the first allocations; the
        // others are left to the predictor.
        add_row(eid_pkg::REQ_LOOKUP, 0, 32'h0,
                1, eid_pkg::ST_OK, 0, 0, 32'h0, 0);
        add_row(eid_pkg::REQ_LOOKUP, 1023, 32'hDEAD_BEEF,
                1, eid_pkg::ST_OK, 0, 0, 32'h0, 0);
        add_row(eid_pkg::REQ_DESTROY, 5, 32'h0,
                1, eid_pkg::ST_NONE, 0, 0, 32'h0, 0);
        add_row(eid_pkg::REQ_DESTROY, 1024, 32'h0,
                1, eid_pkg::ST_RANGE, 0, 0, 32'h0, 0);
        add_row(eid_pkg::REQ_DESTROY, 65535, 32'hFFFF_FFFF,
                1, eid_pkg::ST_RANGE, 0, 0, 32'h0, 0);
        add_row(eid_pkg::REQ_SET, 65535, 32'hFFFF_FFFF,
                1, eid_pkg::ST_RANGE, 0, 0, 32'h0, 0);
        add_row(eid_pkg::REQ_LOOKUP, 65535, 32'h0,
                1, eid_pkg::ST_RANGE, 0, 0, 32'h0, 0);
        add_row(eid_pkg::REQ_SET, 1024, 32'h1234_5678,
                1, eid_pkg::ST_RANGE, 0, 0, 32'h0, 0);
        // create ignores the id field
        add_row(eid_pkg::REQ_CREATE, 65535, 32'hFFFF_FFFF,
                1, eid_pkg::ST_OK, 0, 0, 32'h0, 1);
        add_row(eid_pkg::REQ_CREATE, 0, 32'h0,
                1, eid_pkg::ST_OK, 1, 0, 32'h0, 2);
        add_row(eid_pkg::REQ_SET, 0, 32'hFFFF_FFFF,
                1, eid_pkg::ST_OK, 0, 0, 32'h0, 2);
        add_row(eid_pkg::REQ_LOOKUP, 0, 32'h0,
                1, eid_pkg::ST_OK, 0, 1, 32'hFFFF_FFFF, 2);
        // set on a dead id still writes the word
        add_row(eid_pkg::REQ_SET, 1023, 32'hA5A5_5A5A,
                1, eid_pkg::ST_OK, 0, 0, 32'h0, 2);
        add_row(eid_pkg::REQ_LOOKUP, 1023, 32'h0,
                1, eid_pkg::ST_OK, 0, 0, 32'hA5A5_5A5A, 2);
        add_row(eid_pkg::REQ_DESTROY, 1023, 32'h0,
                1, eid_pkg::ST_DEAD, 0, 0, 32'h0, 2);
        add_row(eid_pkg::REQ_DESTROY, 0, 32'h0,
                1, eid_pkg::ST_OK, 0, 0, 32'h0, 1);
        // destroy clears the signature
        add_row(eid_pkg::REQ_LOOKUP, 0, 32'h0,
                1, eid_pkg::ST_OK, 0, 0, 32'h0, 1);
        // a second destroy must be refused, not pushed twice
        add_row(eid_pkg::REQ_DESTROY, 0, 32'h0,
                1, eid_pkg::ST_DEAD, 0, 0, 32'h0, 1);
        add_row(eid_pkg::REQ_SET, 1, 32'h0,
                0, eid_pkg::ST_OK, 0, 0, 32'h0, 0);
        add_row(eid_pkg::REQ_LOOKUP, 1, 32'hFFFF_FFFF,
                0, eid_pkg::ST_OK, 0, 0, 32'h0, 0);
        add_row(eid_pkg::REQ_CREATE, 32768, 32'h8000_0001,
                1, eid_pkg::ST_OK, 2, 0, 32'h0, 2);
        add_row(eid_pkg::REQ_LOOKUP, 2, 32'h0,
                0, eid_pkg::ST_OK, 0, 0, 32'h0, 0);

        // hold reset, then release it away from the rising edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].item, directed_rows[i].fixed_want,
                         directed_rows[i].want);

        // Mixed random traffic around a small live set.
        repeat (MIX_ITEMS) send_random(MIX_RANDOM);

        // Pause with nothing in flight before the drain.
        hold_until_drained();

        // Drain everything back.
        while (live_total != 0)
            send_random(MIX_DRAIN);

        // Mixed tail: reallocates from the recycled order and hits the
        // none-alive case while the live set is still near empty.
        repeat (TAIL_ITEMS) send_random(MIX_RANDOM);

        hold_until_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
